// ===== rtl/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants for the trial-division prime tester.
// ----------------------------------------------------------------------------
package tdp_pkg;

  // Status returned by the serial remainder unit.
  typedef struct packed {
    logic done;  // one-cycle pulse: remainder is final
    logic zero;  // remainder equals zero, valid with done
  } div_status_t;

  // Wheel constants for the 6k +/- 1 search.
  localparam int unsigned FirstDivisor = 5;
  localparam int unsigned WheelStep    = 6;
  localparam int unsigned PairOffset   = 2;
  localparam int unsigned SmallFactor  = 3;
  localparam int unsigned FirstSquare  = 25;
  // (d + 6)^2 - d^2 = 12 d + 36
  localparam int unsigned SquareOffset = 36;

endpackage

// ===== rtl/tdp_divider.sv =====
// ----------------------------------------------------------------------------
// tdp_divider
// Restoring serial divider that yields the remainder one bit per cycle.
// ----------------------------------------------------------------------------
module tdp_divider #(
  parameter int unsigned ValueWidth = 31
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [ValueWidth-1:0]   dividend_i,
  input  logic [ValueWidth-1:0]   divisor_i,
  output tdp_pkg::div_status_t    status_o
);
  import tdp_pkg::*;

  localparam int unsigned CntWidth = $clog2(ValueWidth);

  logic                  run_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  done_q;
  logic                  zero_q;
  logic [ValueWidth-1:0] dvd_q;
  logic [ValueWidth-1:0] dsr_q;
  logic [ValueWidth-1:0] rem_q;

  logic [ValueWidth:0]   trial;
  logic [ValueWidth:0]   diff;
  logic [ValueWidth-1:0] rem_d;

  // Shift in the next dividend bit, subtract when it fits.
  always_comb begin
    trial = {rem_q, dvd_q[ValueWidth-1]};
    diff  = trial - {1'b0, dsr_q};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = diff[ValueWidth-1:0];
    end else begin
      rem_d = trial[ValueWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntWidth'(ValueWidth - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
          zero_q <= (rem_d == '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[ValueWidth-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign status_o.done = done_q;
  assign status_o.zero = zero_q;

endmodule

// ===== rtl/trial_division_prime_test_top.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Primality test by trial division over the 6k +/- 1 wheel.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+---------------------------
//  command  | in        | start high, busy low   | candidate_i
//  result   | out       | done_o one-cycle pulse | is_prime_o
//
//  Flow: values below 4 and even values finish straight from the check
//  state. Every other value costs one remainder by 3 and then, per divisor
//  pair d, d + 2 while d*d <= value, two remainders plus one bound check.
//  All remainders run one after another on the single serial divider.
//  Reset: asynchronous, active low; returns the sequencer to idle.
//  Stalls: busy is high for the whole test; done_o drops the sequencer back
//  to idle in the same edge, so a new beat may start in the result cycle.
//  The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top #(
  parameter int unsigned ValueWidth = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] candidate_i,
  output logic                  done_o,
  output logic                  is_prime_o
);
  import tdp_pkg::*;

  localparam int unsigned SqWidth = ValueWidth + 2;

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;  // small values and even values
  localparam logic [2:0] StDiv3  = 3'd2;  // wait for value mod 3
  localparam logic [2:0] StBound = 3'd3;  // d*d against value
  localparam logic [2:0] StDivA  = 3'd4;  // wait for value mod d
  localparam logic [2:0] StDivB  = 3'd5;  // wait for value mod (d + 2)

  localparam logic [ValueWidth-1:0] DivFirst = ValueWidth'(FirstDivisor);
  localparam logic [ValueWidth-1:0] DivStep  = ValueWidth'(WheelStep);
  localparam logic [ValueWidth-1:0] DivPair  = ValueWidth'(PairOffset);
  localparam logic [ValueWidth-1:0] DivThree = ValueWidth'(SmallFactor);
  localparam logic [ValueWidth-1:0] ValOne   = ValueWidth'(1);
  localparam logic [ValueWidth-1:0] ValThree = ValueWidth'(3);
  localparam logic [SqWidth-1:0]    SqFirst  = SqWidth'(FirstSquare);
  localparam logic [SqWidth-1:0]    SqOffset = SqWidth'(SquareOffset);

  logic [2:0]            state_q, state_d;
  logic                  done_q, done_d;
  logic                  prime_q, prime_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic [ValueWidth-1:0] div_q, div_d;
  logic [SqWidth-1:0]    sq_q, sq_d;

  logic                  div_start;
  logic [ValueWidth-1:0] div_divisor;
  div_status_t           div_status;
  logic [SqWidth-1:0]    sq_step;

  // (d + 6)^2 = d^2 + 8d + 4d + 36
  assign sq_step = SqWidth'({div_q, 3'b000}) + SqWidth'({div_q, 2'b00}) + SqOffset;

  tdp_divider #(
    .ValueWidth (ValueWidth)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (value_q),
    .divisor_i  (div_divisor),
    .status_o   (div_status)
  );

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    prime_d     = prime_q;
    value_d     = value_q;
    div_d       = div_q;
    sq_d        = sq_q;
    div_start   = 1'b0;
    div_divisor = div_q;

    unique case (state_q)
      StIdle: begin
        // Take the beat and hold the value for the whole test.
        if (start) begin
          value_d = candidate_i;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (value_q <= ValOne) begin
          prime_d = 1'b0;
          done_d  = 1'b1;
          state_d = StIdle;
        end else if (value_q <= ValThree) begin
          prime_d = 1'b1;
          done_d  = 1'b1;
          state_d = StIdle;
        end else if (!value_q[0]) begin
          prime_d = 1'b0;
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          div_start   = 1'b1;
          div_divisor = DivThree;
          state_d     = StDiv3;
        end
      end
      StDiv3: begin
        if (div_status.done) begin
          if (div_status.zero) begin
            prime_d = 1'b0;
            done_d  = 1'b1;
            state_d = StIdle;
          end else begin
            div_d   = DivFirst;
            sq_d    = SqFirst;
            state_d = StBound;
          end
        end
      end
      StBound: begin
        // Past the square root with no factor found: prime.
        if (sq_q > {2'b00, value_q}) begin
          prime_d = 1'b1;
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          div_start   = 1'b1;
          div_divisor = div_q;
          state_d     = StDivA;
        end
      end
      StDivA: begin
        if (div_status.done) begin
          if (div_status.zero) begin
            prime_d = 1'b0;
            done_d  = 1'b1;
            state_d = StIdle;
          end else begin
            div_start   = 1'b1;
            div_divisor = div_q + DivPair;
            state_d     = StDivB;
          end
        end
      end
      StDivB: begin
        if (div_status.done) begin
          if (div_status.zero) begin
            prime_d = 1'b0;
            done_d  = 1'b1;
            state_d = StIdle;
          end else begin
            // Advance to the next pair of the wheel.
            div_d   = div_q + DivStep;
            sq_d    = sq_q + sq_step;
            state_d = StBound;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      prime_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      prime_q <= prime_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
  end

  assign busy       = (state_q != StIdle);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

endmodule
